[rtl/skcf_pkg.sv]
// sky column fade shader package: shared types, constants and blend helpers
// used by the interfaces, the front, the queue, the back and the top level
`timescale 1ns / 1ps

package skcf_pkg;

  localparam int TEXEL_DEPTH = 1024;
  localparam int FRAC_BITS   = 16;
  localparam int ADDR_W      = $clog2(TEXEL_DEPTH);
  localparam int WIDE_W      = 17;
  localparam int PROD_W      = 27;
  localparam int ALPHA_W     = 9;

  localparam logic [31:0]        FADE_BOTTOM_BASE = 32'h0200_0000;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE        = 9'd256;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_START = 2'd1,
    FUNC_DRAW  = 2'd2,
    FUNC_NONE  = 2'd3
  } skcf_func_t;

  typedef enum logic [1:0] {
    CFG_FRAC_STEP      = 2'd0,
    CFG_TEXTURE_HEIGHT = 2'd1,
    CFG_TOP_FADE       = 2'd2,
    CFG_BOTTOM_FADE    = 2'd3
  } skcf_cfg_idx_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_DRAW  = 1'b1
  } skcf_op_t;

  typedef struct packed {
    logic [31:0] frac_step;
    logic [10:0] texture_height;
    logic [23:0] top_fade_rgb;
    logic [23:0] bottom_fade_rgb;
  } skcf_cfg_t;

  typedef struct packed {
    skcf_op_t    op;
    logic [9:0]  addr;
    logic [23:0] rgb;
    logic [31:0] frac;
  } skcf_cmd_t;

  typedef struct packed {
    logic      valid;
    skcf_cmd_t cmd;
  } skcf_slot_t;

  // clamp(v >> 14, 0, 256) with v signed
  function automatic logic [ALPHA_W-1:0] fade_alpha(input logic [31:0] v);
    logic [ALPHA_W-1:0] a;
    if (v[31]) begin
      a = '0;
    end else if (v[30:14] > 17'(ALPHA_ONE)) begin
      a = ALPHA_ONE;
    end else begin
      a = v[22:14];
    end
    return a;
  endfunction

  function automatic logic [23:0] blend_rgb(input logic [23:0] c, input logic [23:0] t,
                                            input logic [ALPHA_W-1:0] a);
    logic [23:0]        r;
    logic [16:0]        m;
    logic [ALPHA_W-1:0] inv;
    inv = ALPHA_ONE - a;
    r = '0;
    for (int s = 0; s < 3; s++) begin
      m = 17'(c[s*8 +: 8]) * 17'(a) + 17'(t[s*8 +: 8]) * 17'(inv);
      r[s*8 +: 8] = m[15:8];
    end
    return r;
  endfunction

endpackage

[rtl/skcf_if.sv]
// request and pixel channel interfaces of the sky column fade shader
// depends on skcf_pkg
`timescale 1ns / 1ps

interface skcf_in_if
  import skcf_pkg::*;
();
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [9:0]  texel_addr;
  logic [23:0] texel_rgb;
  logic [31:0] start_frac;

  modport source (output valid, func, texel_addr, texel_rgb, start_frac, input ready);
  modport sink (input valid, func, texel_addr, texel_rgb, start_frac, output ready);
endinterface

interface skcf_out_if
  import skcf_pkg::*;
();
  logic        valid;
  logic        ready;
  logic [23:0] pixel_rgb;

  modport source (output valid, pixel_rgb, input ready);
  modport sink (input valid, pixel_rgb, output ready);
endinterface

[rtl/skcf_front.sv]
// front: accepts requests, keeps the running fraction, pushes write and draw commands
// depends on skcf_pkg and skcf_if
`timescale 1ns / 1ps

module skcf_front
  import skcf_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  skcf_in_if.sink       in_ch,
  input  skcf_cfg_t     cfg,
  input  logic          q_full,
  output skcf_slot_t    push
);

  logic [31:0] frac;
  logic [31:0] frac_next;
  logic        accept;
  skcf_func_t  func;

  assign func   = skcf_func_t'(in_ch.func);
  assign in_ch.ready = !q_full;
  assign accept = in_ch.valid && in_ch.ready;

  always_comb begin
    frac_next     = frac;
    push.valid    = 1'b0;
    push.cmd.op   = OP_WRITE;
    push.cmd.addr = in_ch.texel_addr;
    push.cmd.rgb  = in_ch.texel_rgb;
    push.cmd.frac = frac;
    if (accept) begin
      unique case (func)
        FUNC_WRITE: begin
          push.valid = 1'b1;
        end
        FUNC_START: begin
          frac_next = in_ch.start_frac;
        end
        FUNC_DRAW: begin
          push.valid  = 1'b1;
          push.cmd.op = OP_DRAW;
          frac_next   = frac + cfg.frac_step;
        end
        default: begin
          frac_next = frac;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frac <= '0;
    end else begin
      frac <= frac_next;
    end
  end

endmodule

[rtl/skcf_queue.sv]
// two-entry command queue between front and back
// depends on skcf_pkg
`timescale 1ns / 1ps

module skcf_queue
  import skcf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  skcf_slot_t push,
  output logic       full,
  output skcf_slot_t head,
  input  logic       pop_ready
);

  skcf_cmd_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full       = (count == 2'd2);
  assign head.valid = (count != 2'd0);
  assign head.cmd   = slots[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = head.valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.cmd;
    end
  end

endmodule

[rtl/skcf_back.sv]
// back: index scaling, texel store access, top and bottom fades, pixel register
// depends on skcf_pkg and skcf_if
`timescale 1ns / 1ps

module skcf_back
  import skcf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  skcf_cfg_t   cfg,
  input  skcf_slot_t  head,
  output logic        pop_ready,
  skcf_out_if.source  out_ch
);

  logic [23:0] texels [TEXEL_DEPTH];

  logic                advance;
  logic                s1_valid;
  skcf_op_t            s1_op;
  logic [WIDE_W-1:0]   s1_addr;
  logic [23:0]         s1_rgb;
  logic [PROD_W-1:0]   s1_prod;
  logic [ALPHA_W-1:0]  s1_atop;
  logic [ALPHA_W-1:0]  s1_abot;
  logic [WIDE_W-1:0]   idx_raw;
  logic [WIDE_W-1:0]   idx;
  logic                s2_valid;
  logic [23:0]         s2_texel;
  logic [ALPHA_W-1:0]  s2_atop;
  logic [ALPHA_W-1:0]  s2_abot;
  logic                s3_valid;
  logic [23:0]         s3_rgb;
  logic [ALPHA_W-1:0]  s3_abot;
  logic                out_valid;
  logic [23:0]         out_rgb;

  assign advance   = !out_valid || out_ch.ready;
  assign pop_ready = advance;
  assign out_ch.valid     = out_valid;
  assign out_ch.pixel_rgb = out_rgb;

  // texel index, clamped to the store
  assign idx_raw = WIDE_W'(s1_prod[PROD_W-1:FRAC_BITS]);
  assign idx = (idx_raw >= WIDE_W'(TEXEL_DEPTH)) ? WIDE_W'(TEXEL_DEPTH - 1) : idx_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= head.valid;
      s2_valid  <= s1_valid && (s1_op == OP_DRAW);
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_op   <= head.cmd.op;
      s1_addr <= WIDE_W'(head.cmd.addr);
      s1_rgb  <= head.cmd.rgb;
      s1_prod <= PROD_W'(head.cmd.frac[23:8]) * PROD_W'(cfg.texture_height);
      s1_atop <= fade_alpha(head.cmd.frac);
      s1_abot <= fade_alpha(FADE_BOTTOM_BASE - head.cmd.frac);

      // one store access per cycle while the pipeline advances: a write or a read
      if (s1_valid && (s1_op == OP_WRITE)) begin
        if (s1_addr < WIDE_W'(TEXEL_DEPTH)) begin
          texels[s1_addr[ADDR_W-1:0]] <= s1_rgb;
        end
      end else begin
        s2_texel <= texels[idx[ADDR_W-1:0]];
      end
      s2_atop  <= s1_atop;
      s2_abot  <= s1_abot;

      s3_rgb  <= blend_rgb(s2_texel, cfg.top_fade_rgb, s2_atop);
      s3_abot <= s2_abot;

      out_rgb <= blend_rgb(s3_rgb, cfg.bottom_fade_rgb, s3_abot);
    end
  end

endmodule

[rtl/sky_column_fade_shader_top.sv]
// sky column fade shader top level: configuration registers, front, queue and back
// depends on skcf_pkg, skcf_if, skcf_front, skcf_queue and skcf_back
`timescale 1ns / 1ps

// Takes one request per clock while the two-entry command queue has room. Start
// requests load the running fraction in the front; write and draw requests enter
// the queue. The back pipeline is four stages: index multiply and fade alphas,
// texel store access, top fade, bottom fade into the pixel register, one pixel
// per clock while the pixel register is not stalled. A stalled pixel register
// freezes the whole back pipeline; the queue then fills and ready drops. The
// texel store is a single-port 1024 x 24 memory: in each advancing cycle it is
// either written or read. Configuration is written through cfg_wr_en, cfg_index
// and cfg_data while idle, which binds the user; the block does not enforce it.
module sky_column_fade_shader_top
  import skcf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  skcf_in_if.sink     in_ch,
  skcf_out_if.source  out_ch,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  skcf_cfg_t  cfg;
  skcf_slot_t push;
  skcf_slot_t head;
  logic       q_full;
  logic       pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frac_step       <= '0;
      cfg.texture_height  <= 11'd1024;
      cfg.top_fade_rgb    <= '0;
      cfg.bottom_fade_rgb <= '0;
    end else if (cfg_wr_en) begin
      unique case (skcf_cfg_idx_t'(cfg_index))
        CFG_FRAC_STEP:      cfg.frac_step       <= cfg_data;
        CFG_TEXTURE_HEIGHT: cfg.texture_height  <= cfg_data[10:0];
        CFG_TOP_FADE:       cfg.top_fade_rgb    <= cfg_data[23:0];
        CFG_BOTTOM_FADE:    cfg.bottom_fade_rgb <= cfg_data[23:0];
        default:            cfg.frac_step       <= cfg.frac_step;
      endcase
    end
  end

  skcf_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .cfg    (cfg),
    .q_full (q_full),
    .push   (push)
  );

  skcf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (q_full),
    .head      (head),
    .pop_ready (pop_ready)
  );

  skcf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

  // the front never pushes into a full queue
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !q_full)
    else $error("command pushed into full queue");

  // a stalled pixel freezes the back, so nothing leaves the queue
  a_no_pop_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |-> !pop_ready)
    else $error("queue popped while pixel stalled");

  // a start or idle request never enters the queue
  a_start_not_queued: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready && (in_ch.func == FUNC_START || in_ch.func == FUNC_NONE))
    |-> !push.valid)
    else $error("start request pushed into queue");

endmodule

[bench/skcf_tb_pkg.sv]
// sky column fade shader bench package: request record and pixel scoreboard
// the scoreboard keeps its own texel store, column fraction and register copy
// depends on skcf_pkg
`timescale 1ns / 1ps

package skcf_tb_pkg;
  import skcf_pkg::*;

  typedef struct packed {
    skcf_func_t  func;
    logic [9:0]  addr;
    logic [23:0] rgb;
    logic [31:0] frac;
  } shade_req_t;

  class pixel_scoreboard;
    logic [23:0] texels [TEXEL_DEPTH];
    bit          texel_written [TEXEL_DEPTH];
    logic [31:0] column_frac;
    logic [31:0] frac_step;
    logic [10:0] tex_height;
    logic [23:0] top_rgb;
    logic [23:0] bottom_rgb;
    logic [23:0] pending_pixels [$];
    int unsigned errors;

    function new();
      foreach (texel_written[i]) texel_written[i] = 1'b0;
      column_frac = '0;
      frac_step   = '0;
      tex_height  = 11'd1024;
      top_rgb     = '0;
      bottom_rgb  = '0;
      errors      = 0;
    endfunction

    function void set_reg(skcf_cfg_idx_t idx, logic [31:0] data);
      case (idx)
        CFG_FRAC_STEP:      frac_step  = data;
        CFG_TEXTURE_HEIGHT: tex_height = data[10:0];
        CFG_TOP_FADE:       top_rgb    = data[23:0];
        CFG_BOTTOM_FADE:    bottom_rgb = data[23:0];
        default: ;
      endcase
    endfunction

    // texel row the next draw reads
    function logic [9:0] texel_index();
      logic [26:0] scaled;
      scaled = 27'(column_frac[23:8]) * 27'(tex_height);
      if (int'(scaled[26:16]) >= TEXEL_DEPTH) begin
        return 10'(TEXEL_DEPTH - 1);
      end
      return scaled[25:16];
    endfunction

    function logic [8:0] fade_weight(logic [31:0] v);
      logic [16:0] q;
      q = v[30:14];
      if (v[31]) begin
        return 9'd0;
      end else if (q > 17'd256) begin
        return 9'd256;
      end
      return q[8:0];
    endfunction

    function logic [23:0] mix_toward(logic [23:0] c, logic [23:0] t, logic [8:0] a);
      logic [23:0] r;
      logic [16:0] m;
      logic [8:0]  inv;
      inv = 9'd256 - a;
      r = '0;
      for (int s = 0; s < 24; s += 8) begin
        m = 17'(c[s +: 8]) * 17'(a) + 17'(t[s +: 8]) * 17'(inv);
        r[s +: 8] = m[15:8];
      end
      return r;
    endfunction

    function logic [23:0] shade_pixel();
      logic [23:0] c;
      logic [8:0]  a_top;
      logic [8:0]  a_bot;
      c = texels[texel_index()];
      a_top = fade_weight(column_frac);
      a_bot = fade_weight(FADE_BOTTOM_BASE - column_frac);
      c = mix_toward(c, top_rgb, a_top);
      return mix_toward(c, bottom_rgb, a_bot);
    endfunction

    function void note_request(shade_req_t req);
      case (req.func)
        FUNC_WRITE: begin
          texels[req.addr] = req.rgb;
          texel_written[req.addr] = 1'b1;
        end
        FUNC_START: column_frac = req.frac;
        FUNC_DRAW: begin
          pending_pixels.push_back(shade_pixel());
          column_frac = column_frac + frac_step;
        end
        default: ;
      endcase
    endfunction

    function void check_pixel(logic [23:0] rgb);
      logic [23:0] want;
      if (pending_pixels.size() == 0) begin
        $display("%0t pixel mismatch: expected none actual %06h", $time, rgb);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (want !== rgb) begin
          $display("%0t pixel mismatch: expected %06h actual %06h", $time, want, rgb);
          errors++;
        end
      end
    endfunction
  endclass

endpackage

[bench/testbench.sv]
// sky column fade shader testbench: directed fade edges, then random columns
// under several register settings, pixels checked against the scoreboard
// depends on skcf_pkg, skcf_if, skcf_tb_pkg and sky_column_fade_shader_top
`timescale 1ns / 1ps

module testbench;
  import skcf_pkg::*;
  import skcf_tb_pkg::*;

  localparam int DRAIN_CYCLES = 16;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 1600;
  localparam int PHASES       = 8;

  localparam logic [31:0] EDGE_FRACS [10] = '{
    32'h0000_0000, 32'h0000_4000, 32'h003F_C000, 32'h0040_0000, 32'h00FF_FF00,
    32'h01FF_C000, 32'h0200_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  bit          steady = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned sent = 0;
  pixel_scoreboard book;

  skcf_in_if  in_ch();
  skcf_out_if out_ch();

  sky_column_fade_shader_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ch.ready = steady || ($urandom_range(99) >= 9);
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      book.check_pixel(out_ch.pixel_rgb);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic shade_req_t make_req(skcf_func_t f, logic [9:0] a, logic [23:0] c,
                                          logic [31:0] fr);
    shade_req_t r;
    r.func = f;
    r.addr = a;
    r.rgb  = c;
    r.frac = fr;
    return r;
  endfunction

  task automatic send(input shade_req_t req);
    while (!steady && $urandom_range(99) < 9) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_ch.valid      = 1'b1;
    in_ch.func       = req.func;
    in_ch.texel_addr = req.addr;
    in_ch.texel_rgb  = req.rgb;
    in_ch.start_frac = req.frac;
    do begin
      @(posedge clk);
    end while (in_ch.ready !== 1'b1);
    book.note_request(req);
    if (req.func != FUNC_NONE) sent++;
  endtask

  task automatic write_texel(input logic [9:0] addr, input logic [23:0] rgb);
    send(make_req(FUNC_WRITE, addr, rgb, $urandom));
  endtask

  task automatic start_column(input logic [31:0] fr);
    send(make_req(FUNC_START, 10'($urandom), 24'($urandom), fr));
  endtask

  // never read a texel row that was not loaded
  task automatic draw_pixel();
    logic [9:0] idx;
    idx = book.texel_index();
    if (!book.texel_written[idx]) write_texel(idx, 24'($urandom));
    send(make_req(FUNC_DRAW, 10'($urandom), 24'($urandom), $urandom));
  endtask

  task automatic settle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (book.pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input skcf_cfg_idx_t idx, input logic [31:0] data);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    book.set_reg(idx, data);
  endtask

  task automatic apply_setting(input logic [31:0] step, input logic [10:0] height,
                               input logic [23:0] top, input logic [23:0] bottom);
    settle();
    write_reg(CFG_FRAC_STEP, step);
    write_reg(CFG_TEXTURE_HEIGHT, 32'(height));
    write_reg(CFG_TOP_FADE, 32'(top));
    write_reg(CFG_BOTTOM_FADE, 32'(bottom));
  endtask

  task automatic run_phase(input int unsigned n);
    int unsigned goal;
    int unsigned pick;
    int unsigned span;
    logic [31:0] fr;
    goal = sent + n;
    while (sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        // column through the fade band, sometimes anywhere
        if ($urandom_range(4) == 0) begin
          fr = $urandom;
        end else begin
          fr = $urandom_range(32'h0240_0000) - 32'h0020_0000;
        end
        start_column(fr);
        span = $urandom_range(1, 24);
        repeat (span) begin
          if ($urandom_range(9) == 0) write_texel(10'($urandom), 24'($urandom));
          draw_pixel();
        end
      end else if (pick < 85) begin
        write_texel(10'($urandom), 24'($urandom));
      end else if (pick < 90) begin
        draw_pixel();
      end else if (pick < 95) begin
        start_column($urandom);
      end else begin
        send(make_req(FUNC_NONE, 10'($urandom), 24'($urandom), $urandom));
      end
    end
  endtask

  initial begin
    logic [31:0] st;
    book = new();
    in_ch.valid      = 1'b0;
    in_ch.func       = FUNC_NONE;
    in_ch.texel_addr = '0;
    in_ch.texel_rgb  = '0;
    in_ch.start_frac = '0;
    out_ch.ready     = 1'b0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    apply_setting(32'h0010_0000, 11'd1024, 24'hFF8000, 24'h0040FF);
    write_texel(10'd0, 24'hFFFFFF);
    write_texel(10'd1023, 24'h000000);
    send(make_req(FUNC_NONE, 10'h3FF, 24'hFFFFFF, 32'hFFFF_FFFF));
    foreach (EDGE_FRACS[i]) begin
      start_column(EDGE_FRACS[i]);
      draw_pixel();
    end
    draw_pixel();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: apply_setting(32'h0000_0000, 11'd1, 24'h000000, 24'h000000);
        1: apply_setting(32'h7FFF_FFFF, 11'd2047, 24'hFFFFFF, 24'hFFFFFF);
        2: apply_setting(32'h8000_0000, 11'd0, 24'hFFFFFF, 24'h000000);
        default: begin
          st = $urandom_range(32'h0004_0000);
          if ($urandom_range(1) == 1) st = -st;
          apply_setting(st, 11'($urandom_range(1, 1024)), 24'($urandom), 24'($urandom));
        end
      endcase
      steady = (p == 5);
      run_phase(RANDOM_ITEMS / PHASES);
    end
    steady = 1'b0;

    settle();
    if (book.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/skcf_pkg.sv
rtl/skcf_if.sv
rtl/skcf_front.sv
rtl/skcf_queue.sv
rtl/skcf_back.sv
rtl/sky_column_fade_shader_top.sv
bench/skcf_tb_pkg.sv
bench/testbench.sv
